// File: rtl/s3wp_pkg.sv
// shared types and constants of the stable three-way partition block
package s3wp_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned GRP_W         = 2;

  // group codes, also the order of the scan passes
  typedef enum logic [GRP_W-1:0] {
    GRP_BELOW = 2'd0,
    GRP_EQUAL = 2'd1,
    GRP_ABOVE = 2'd2
  } grp_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // word accepted this cycle
    logic scan;   // issue one store read
    logic flush;  // last read in flight, clear sequence state
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // final read of the final pass is issued now
  } status_t;

endpackage

// File: rtl/stable_three_way_partition.sv
// top level of the stable three-way partition block
//
// Words are loaded one per clock while busy is low. A word with
// in_final_item set closes the sequence and starts a walk over the store:
// one pass per group (below, equal, above the pivot), one stored word read
// per cycle through the single read port of the store, while busy stays
// high. Results appear in partitioned, stable order, each for exactly one
// cycle under out_valid, after the store's read register and the result
// register; the receiver cannot stall them. Words beyond MAX_ITEMS are
// dropped and reported in out_overflowed. The pivot is to be written through
// the cfg port between sequences; the block itself does not enforce this.
module stable_three_way_partition #(
  parameter int unsigned MAX_ITEMS = s3wp_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [s3wp_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_final_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [s3wp_pkg::VALUE_W-1:0] cfg_data,
  output logic                                out_valid,
  output logic signed [s3wp_pkg::VALUE_W-1:0] out_value,
  output logic [s3wp_pkg::GRP_W-1:0]          out_group,
  output logic                                out_last_of_run,
  output logic                                out_overflowed
);

  s3wp_pkg::cmd_t    cmd;
  s3wp_pkg::status_t status;

  assign cfg_ready = 1'b1;

  s3wp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_final_item(in_final_item),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  s3wp_dp #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_value),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_group      (out_group),
    .out_last_of_run(out_last_of_run),
    .out_overflowed (out_overflowed)
  );

  // a closing word always starts the walk
  a_final_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_final_item) |=> busy)
    else $error("final word did not start the walk");

  // nothing follows the last word of a run
  a_last_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |=> !out_valid)
    else $error("result after end of run");

  // while more words of the run are due the block stays busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> busy)
    else $error("run unfinished but block idle");

  a_group_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_group == s3wp_pkg::GRP_BELOW || out_group == s3wp_pkg::GRP_EQUAL
                   || out_group == s3wp_pkg::GRP_ABOVE))
    else $error("bad group code");

endmodule

// File: rtl/s3wp_ram.sv
// generic single write port ram with registered read
module s3wp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/s3wp_ctrl.sv
// sequencer for load, scan and flush phases
module s3wp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_final_item,
  input  s3wp_pkg::status_t status,
  output s3wp_pkg::cmd_t    cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (start && in_final_item) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_LOAD);
  assign cmd.load  = (state_r == S_LOAD) && start;
  assign cmd.scan  = (state_r == S_SCAN);
  assign cmd.flush = (state_r == S_FLUSH);

endmodule

// File: rtl/s3wp_dp.sv
// datapath: store, counters, pivot compare and result register
module s3wp_dp #(
  parameter int unsigned MAX_ITEMS = s3wp_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  s3wp_pkg::cmd_t                      cmd,
  output s3wp_pkg::status_t                   status,
  input  logic signed [s3wp_pkg::VALUE_W-1:0] in_value,
  input  logic                                cfg_valid,
  input  logic signed [s3wp_pkg::VALUE_W-1:0] cfg_data,
  output logic                                out_valid,
  output logic signed [s3wp_pkg::VALUE_W-1:0] out_value,
  output logic [s3wp_pkg::GRP_W-1:0]          out_group,
  output logic                                out_last_of_run,
  output logic                                out_overflowed
);

  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);

  logic signed [s3wp_pkg::VALUE_W-1:0] pivot_r;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic                                ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]                   addr_r, addr_nxt;
  s3wp_pkg::grp_t                      pass_r, pass_nxt;
  logic                                rd_vld_r;
  s3wp_pkg::grp_t                      rd_grp_r;
  logic [CNT_W-1:0]                    emit_r, emit_nxt;
  logic signed [s3wp_pkg::VALUE_W-1:0] rd_data;
  s3wp_pkg::grp_t                      data_grp;
  logic                                store_we;
  logic                                addr_end;
  logic                                hit;

  logic                                out_valid_r;
  logic signed [s3wp_pkg::VALUE_W-1:0] out_value_r;
  s3wp_pkg::grp_t                      out_group_r;
  logic                                out_last_r;
  logic                                out_ovf_r;

  s3wp_ram #(
    .WIDTH(s3wp_pkg::VALUE_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(count_r[ADDR_W-1:0]),
    .wdata(in_value),
    .raddr(addr_r),
    .rdata(rd_data)
  );

  assign store_we = cmd.load && (count_r < CNT_W'(MAX_ITEMS));
  assign addr_end = (CNT_W'(addr_r) == count_r - CNT_W'(1));
  assign status.scan_last = cmd.scan && (pass_r == s3wp_pkg::GRP_ABOVE) && addr_end;

  // word counter and overflow, cleared once the last read is in flight
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.flush) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (store_we) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.load) begin
      ovf_nxt = 1'b1;
    end
  end

  // scan walks the store once per group
  always_comb begin
    addr_nxt = addr_r;
    pass_nxt = pass_r;
    if (cmd.flush) begin
      addr_nxt = '0;
      pass_nxt = s3wp_pkg::GRP_BELOW;
    end else if (cmd.scan) begin
      if (addr_end) begin
        addr_nxt = '0;
        case (pass_r)
          s3wp_pkg::GRP_BELOW: pass_nxt = s3wp_pkg::GRP_EQUAL;
          s3wp_pkg::GRP_EQUAL: pass_nxt = s3wp_pkg::GRP_ABOVE;
          default:             pass_nxt = s3wp_pkg::GRP_BELOW;
        endcase
      end else begin
        addr_nxt = addr_r + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    if (rd_data < pivot_r) begin
      data_grp = s3wp_pkg::GRP_BELOW;
    end else if (rd_data == pivot_r) begin
      data_grp = s3wp_pkg::GRP_EQUAL;
    end else begin
      data_grp = s3wp_pkg::GRP_ABOVE;
    end
  end

  assign hit = rd_vld_r && (data_grp == rd_grp_r);

  always_comb begin
    emit_nxt = emit_r;
    if (cmd.flush) begin
      emit_nxt = '0;
    end else if (hit) begin
      emit_nxt = emit_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r     <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      addr_r      <= '0;
      pass_r      <= s3wp_pkg::GRP_BELOW;
      rd_vld_r    <= 1'b0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pivot_r <= cfg_data;
      end
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      addr_r      <= addr_nxt;
      pass_r      <= pass_nxt;
      rd_vld_r    <= cmd.scan;
      emit_r      <= emit_nxt;
      out_valid_r <= hit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_grp_r <= pass_r;
    if (hit) begin
      out_value_r <= rd_data;
      out_group_r <= rd_grp_r;
      // every stored word lands in exactly one group
      out_last_r  <= (emit_r == count_r - CNT_W'(1));
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_group       = out_group_r;
  assign out_last_of_run = out_last_r;
  assign out_overflowed  = out_ovf_r;

endmodule

// File: tb/stable_three_way_partition_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the stable three-way partition block
module stable_three_way_partition_test;

  localparam int unsigned DEPTH      = s3wp_pkg::MAX_ITEMS_DEF;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam int unsigned PHASE_SIZE = 137;

  typedef logic signed [s3wp_pkg::VALUE_W-1:0] word_t;

  localparam word_t MOST_NEG = {1'b1, {(s3wp_pkg::VALUE_W-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(s3wp_pkg::VALUE_W-1){1'b1}}};

  typedef struct {
    word_t          value;
    s3wp_pkg::grp_t grp;
    logic           last;
    logic           ovf;
  } run_word_t;

  // keeps the sequence being loaded and the partitioned words still owed
  class partition_scoreboard;
    word_t       held[DEPTH];
    int unsigned held_count;
    bit          dropped;
    word_t       pivot_key;
    run_word_t   expected_words[$];
    int unsigned errors;

    function new();
      held_count = 0;
      dropped    = 0;
      pivot_key  = '0;
      errors     = 0;
    endfunction

    function void set_pivot(word_t p);
      pivot_key = p;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function s3wp_pkg::grp_t group_for(word_t v);
      if (v < pivot_key) return s3wp_pkg::GRP_BELOW;
      if (v == pivot_key) return s3wp_pkg::GRP_EQUAL;
      return s3wp_pkg::GRP_ABOVE;
    endfunction

    function void note_word(word_t v, logic fin);
      s3wp_pkg::grp_t pass_order[3];
      run_word_t      w;
      pass_order = '{s3wp_pkg::GRP_BELOW, s3wp_pkg::GRP_EQUAL, s3wp_pkg::GRP_ABOVE};
      if (held_count < DEPTH) begin
        held[held_count] = v;
        held_count++;
      end else begin
        dropped = 1'b1;
      end
      if (!fin) return;
      // one pass per group keeps arrival order inside each group
      foreach (pass_order[g]) begin
        for (int unsigned i = 0; i < held_count; i++) begin
          if (group_for(held[i]) == pass_order[g]) begin
            w.value = held[i];
            w.grp   = pass_order[g];
            w.last  = 1'b0;
            w.ovf   = dropped;
            expected_words.push_back(w);
          end
        end
      end
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
      held_count = 0;
      dropped    = 1'b0;
    endfunction

    function void check_word(word_t v, logic [s3wp_pkg::GRP_W-1:0] g, logic last,
                             logic ovf);
      run_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: value %0d group %0d last %0b overflowed %0b",
                 $time, v, g, last, ovf);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (v !== w.value) begin
        $display("%0t: out_value expected %0d actual %0d", $time, w.value, v);
        errors++;
      end
      if (g !== w.grp) begin
        $display("%0t: out_group expected %0d actual %0d", $time, w.grp, g);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: out_last_of_run expected %0b actual %0b", $time, w.last, last);
        errors++;
      end
      if (ovf !== w.ovf) begin
        $display("%0t: out_overflowed expected %0b actual %0b", $time, w.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  word_t                         in_value;
  logic                          in_final_item;
  logic                          cfg_valid;
  logic                          cfg_ready;
  word_t                         cfg_data;
  logic                          out_valid;
  word_t                         out_value;
  logic [s3wp_pkg::GRP_W-1:0]    out_group;
  logic                          out_last_of_run;
  logic                          out_overflowed;

  partition_scoreboard board = new();
  word_t               current_pivot = '0;
  int unsigned         idle_pct = 0;
  int unsigned         quiet_cycles = 0;

  stable_three_way_partition dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_final_item   (in_final_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_group       (out_group),
    .out_last_of_run (out_last_of_run),
    .out_overflowed  (out_overflowed)
  );

  always #4 clk = ~clk;

  // results are checked before the word of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        board.check_word(out_value, out_group, out_last_of_run, out_overflowed);
      if (start && !busy)
        board.note_word(in_value, in_final_item);
      if (cfg_valid && cfg_ready)
        board.set_pivot(cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_MAX) begin
      $display("stable_three_way_partition regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(6, 1);
    if (r < 95) return $urandom_range(20, 7);
    return $urandom_range(40, 21);
  endfunction

  // values cluster around the pivot so that all three groups stay busy
  function automatic word_t pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return current_pivot;
    if (r < 45) return current_pivot - word_t'($urandom_range(3, 1));
    if (r < 65) return current_pivot + word_t'($urandom_range(3, 1));
    if (r < 75) return ($urandom_range(1) != 0) ? MOST_POS : MOST_NEG;
    return word_t'($urandom);
  endfunction

  task automatic send_word(word_t v, logic fin);
    while ($urandom_range(99) < idle_pct) @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start         <= 1'b1;
    in_value      <= v;
    in_final_item <= fin;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (board.pending() != 0 || busy) @(posedge clk);
    // a pause before the next sequence; the walk is already over here
    repeat (8) @(posedge clk);
  endtask

  task automatic write_pivot(word_t p);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    current_pivot = p;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // mostly short sequences, one long one that fills or overruns the store
  task automatic run_phase(int unsigned long_len);
    int unsigned sent;
    int unsigned len;
    bit          long_done;
    sent      = 0;
    long_done = 0;
    while (sent < PHASE_SIZE) begin
      if (!long_done && sent >= 40) begin
        len       = long_len;
        long_done = 1;
      end else begin
        len = pick_length();
      end
      for (int unsigned i = 0; i < len; i++)
        send_word(pick_value(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    word_t       p;
    int unsigned long_lens[3];
    long_lens     = '{DEPTH + 2, DEPTH, DEPTH + 1};
    rst_n         = 1'b0;
    start         = 1'b0;
    in_value      = '0;
    in_final_item = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // pivot still at its reset value of zero
    send_word(0, 1'b1);
    send_word(MOST_NEG, 1'b0);
    send_word(MOST_POS, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word(0, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b1);

    // nothing can sit below the most negative pivot
    wait_drained();
    write_pivot(MOST_NEG);
    send_word(MOST_NEG, 1'b0);
    send_word(5, 1'b0);
    send_word(MOST_NEG, 1'b1);

    // nothing can sit above the most positive pivot
    wait_drained();
    write_pivot(MOST_POS);
    send_word(MOST_POS, 1'b0);
    send_word(MOST_NEG, 1'b0);
    send_word(7, 1'b0);
    send_word(MOST_POS, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          p        = word_t'($urandom);
          idle_pct = 6;
        end
        1: begin
          p        = -word_t'($urandom_range(50, 1));
          idle_pct = 70;
        end
        default: begin
          p        = word_t'($urandom_range(20));
          idle_pct = 0;
        end
      endcase
      write_pivot(p);
      run_phase(long_lens[phase]);
    end

    wait_drained();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("stable_three_way_partition regression: pass");
    end else begin
      $display("stable_three_way_partition regression: fail");
    end
    $finish;
  end

endmodule
